// File: rtl/rfta_pkg.sv
package rfta_pkg;

    // Table sizes. Region frames are handed out in fill order, so the frame
    // number of a region is the index of the cell that holds it.
    localparam int REGION_ENTRIES = 64;
    localparam int PAGE_ENTRIES   = 256;

    localparam int ADDR_W  = 64;
    localparam int SHIFT_W = 6;
    localparam int FRAME_W = (REGION_ENTRIES > 1) ? $clog2(REGION_ENTRIES) : 1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SHIFT = 1'b1;

    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RESET   = 6'd12;
    localparam logic [SHIFT_W-1:0] REGION_SHIFT_RESET = 6'd12;

    // Transfer moving along the region chain.
    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  va;
        logic [SHIFT_W-1:0] rs;
        logic [SHIFT_W-1:0] ps;
        logic [ADDR_W-1:0]  key;
        logic               found;
        logic               alloc;
        logic [FRAME_W-1:0] frame;
    } region_tok_t;

    // Transfer moving along the page chain.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] pa;
        logic [ADDR_W-1:0] vpn;
        logic              alloc;
        logic              skip;
        logic              done;
        logic              recorded;
    } page_tok_t;

    // One finished result.
    typedef struct packed {
        logic [ADDR_W-1:0] pa;
        logic              alloc;
        logic              recorded;
        logic              full;
    } result_t;

endpackage

// File: rtl/region_first_touch_allocator.sv
// First-touch region allocator. A virtual address enters on the request
// channel (req_valid / req_stall) and one result leaves on the response channel
// (rsp_valid / rsp_stall): the physical address, whether this access allocated
// a new region, whether it was the first touch of its page, and whether a
// needed table entry could not be stored. A transfer happens at a rising edge
// where valid is high and stall is low. Page and region shifts are written on
// the plain register port (cfg_we, cfg_index, cfg_data); the user must write
// them only while the block is idle, which the block itself does not enforce.
// Every request walks the two chains of table cells, one cell per cycle,
// and a new request enters every cycle, both while the result queue has room.
// Reset empties both tables, restarts frame numbering at zero and loads both
// shifts with 12. When the receiver stalls, a two-entry result queue absorbs
// the results in flight; once it is full the whole chain holds and req_stall
// rises until a result is taken.
module region_first_touch_allocator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rfta_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfta_pkg::SHIFT_W-1:0]    cfg_data,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [rfta_pkg::ADDR_W-1:0]     virt_addr,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [rfta_pkg::ADDR_W-1:0]     phys_addr,
    output logic                            region_allocated,
    output logic                            page_recorded,
    output logic                            table_full
);
    import rfta_pkg::*;

    logic [SHIFT_W-1:0] page_shift_reg;
    logic [SHIFT_W-1:0] region_shift_reg;
    logic [SHIFT_W-1:0] eff_shift;

    // The whole chain moves together; it holds only while the result queue
    // has no room for another result.
    logic advance;

    region_tok_t region_link [REGION_ENTRIES+1];
    page_tok_t   page_link   [PAGE_ENTRIES+1];
    region_tok_t entry_reg;
    region_tok_t entry_next;
    page_tok_t   bridge_reg;
    page_tok_t   bridge_next;
    region_tok_t region_last;
    page_tok_t   page_last;
    result_t     result;
    result_t     rsp_head;

    logic [REGION_ENTRIES-1:0] region_occ;
    logic [PAGE_ENTRIES-1:0]   page_occ;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_shift_reg   <= PAGE_SHIFT_RESET;
            region_shift_reg <= REGION_SHIFT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PAGE_SHIFT:   page_shift_reg   <= cfg_data;
                CFG_REGION_SHIFT: region_shift_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // The region can never be smaller than a page.
    assign eff_shift = (region_shift_reg < page_shift_reg) ? page_shift_reg : region_shift_reg;

    // Entry stage: the region number is formed here so that the first cell
    // sees a plain compare.
    always_comb
    begin
        entry_next       = '0;
        entry_next.valid = req_valid;
        entry_next.va    = virt_addr;
        entry_next.rs    = eff_shift;
        entry_next.ps    = page_shift_reg;
        entry_next.key   = virt_addr >> eff_shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (advance)
        begin
            entry_reg <= entry_next;
        end
    end

    assign region_link[0] = entry_reg;

    // Region chain. Each cell holds one region number; its frame number is
    // its own position in the chain.
    for (genvar i = 0; i < REGION_ENTRIES; i++)
    begin : g_region
        rfta_region_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .index      (FRAME_W'(i)),
            .upstream   (region_link[i]),
            .downstream (region_link[i+1]),
            .occupied   (region_occ[i])
        );
    end

    assign region_last = region_link[REGION_ENTRIES];

    // Bridge stage: build the physical address and the page number. A request
    // whose region found no room skips the page table and reports zero.
    always_comb
    begin
        bridge_next          = '0;
        bridge_next.valid    = region_last.valid;
        bridge_next.alloc    = region_last.alloc;
        bridge_next.vpn      = region_last.va >> region_last.ps;
        bridge_next.skip     = !region_last.found;
        bridge_next.done     = !region_last.found;
        bridge_next.recorded = 1'b0;
        if (region_last.found)
        begin
            bridge_next.pa = (ADDR_W'(region_last.frame) << region_last.rs)
                           | (region_last.va & ~({ADDR_W{1'b1}} << region_last.rs));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bridge_reg <= '0;
        end
        else if (advance)
        begin
            bridge_reg <= bridge_next;
        end
    end

    assign page_link[0] = bridge_reg;

    // Page chain. Each cell remembers one virtual page number that was seen.
    for (genvar j = 0; j < PAGE_ENTRIES; j++)
    begin : g_page
        rfta_page_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .upstream   (page_link[j]),
            .downstream (page_link[j+1]),
            .occupied   (page_occ[j])
        );
    end

    assign page_last = page_link[PAGE_ENTRIES];

    // A request that reaches the end of the page chain still undecided found
    // neither its page nor a free cell.
    always_comb
    begin
        result          = '0;
        result.pa       = page_last.pa;
        result.alloc    = page_last.alloc;
        result.recorded = page_last.recorded;
        result.full     = page_last.skip || !page_last.done;
    end

    rfta_out_queue u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (advance && page_last.valid),
        .entry (result),
        .room  (advance),
        .valid (rsp_valid),
        .stall (rsp_stall),
        .head  (rsp_head)
    );

    assign req_stall        = !advance;
    assign phys_addr        = rsp_head.pa;
    assign region_allocated = rsp_head.alloc;
    assign page_recorded    = rsp_head.recorded;
    assign table_full       = rsp_head.full;

    // Occupied region cells always form an unbroken run from the head.
    assert property (@(posedge clk) disable iff (!rst_n)
        (region_occ & (region_occ + 1'b1)) == '0)
        else $error("region cells not filled in order");

    // The same holds for the page cells.
    assert property (@(posedge clk) disable iff (!rst_n)
        (page_occ & (page_occ + 1'b1)) == '0)
        else $error("page cells not filled in order");

    // A region, once allocated, is never released.
    assert property (@(posedge clk) disable iff (!rst_n)
        (region_occ & $past(region_occ)) == $past(region_occ))
        else $error("region entry lost");

    // A page that was stored cannot also report a full table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && page_recorded) |-> !table_full)
        else $error("page recorded together with table full");

endmodule

// File: rtl/rfta_region_cell.sv
module rfta_region_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [rfta_pkg::FRAME_W-1:0]  index,
    input  rfta_pkg::region_tok_t         upstream,
    output rfta_pkg::region_tok_t         downstream,
    output logic                          occupied
);
    import rfta_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [ADDR_W-1:0] number_reg;
    logic [ADDR_W-1:0] number_next;
    region_tok_t       down_reg;
    region_tok_t       down_next;

    // The first empty cell a missing region reaches is the lowest free slot,
    // since cells fill from the head of the chain and are never released.
    always_comb
    begin
        down_next   = upstream;
        valid_next  = valid_reg;
        number_next = number_reg;
        if (upstream.valid && !upstream.found)
        begin
            if (valid_reg)
            begin
                if (number_reg == upstream.key)
                begin
                    down_next.found = 1'b1;
                    down_next.frame = index;
                end
            end
            else
            begin
                valid_next      = 1'b1;
                number_next     = upstream.key;
                down_next.found = 1'b1;
                down_next.alloc = 1'b1;
                down_next.frame = index;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            down_reg  <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
            down_reg  <= down_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            number_reg <= number_next;
        end
    end

    assign downstream = down_reg;
    assign occupied   = valid_reg;

endmodule

// File: rtl/rfta_page_cell.sv
module rfta_page_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  rfta_pkg::page_tok_t upstream,
    output rfta_pkg::page_tok_t downstream,
    output logic                occupied
);
    import rfta_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [ADDR_W-1:0] number_reg;
    logic [ADDR_W-1:0] number_next;
    page_tok_t         down_reg;
    page_tok_t         down_next;

    always_comb
    begin
        down_next   = upstream;
        valid_next  = valid_reg;
        number_next = number_reg;
        if (upstream.valid && !upstream.done)
        begin
            if (valid_reg)
            begin
                if (number_reg == upstream.vpn)
                begin
                    down_next.done = 1'b1;
                end
            end
            else
            begin
                valid_next         = 1'b1;
                number_next        = upstream.vpn;
                down_next.done     = 1'b1;
                down_next.recorded = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            down_reg  <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
            down_reg  <= down_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            number_reg <= number_next;
        end
    end

    assign downstream = down_reg;
    assign occupied   = valid_reg;

endmodule

// File: rtl/rfta_out_queue.sv
module rfta_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rfta_pkg::result_t entry,
    output logic              room,
    output logic              valid,
    input  logic              stall,
    output rfta_pkg::result_t head
);
    import rfta_pkg::*;

    result_t    mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign pop   = valid && !stall;
    assign valid = (count_reg != 2'd0);
    assign room  = (count_reg != 2'd2);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= entry;
        end
    end

endmodule

// File: verif/rfta_translation_check.sv
// Watches the register port and both channels of the first-touch allocator.
// It predicts every result from its own copy of the tables and the shifts.
// Each returned result is compared with the oldest prediction.
module rfta_translation_check (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rfta_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfta_pkg::SHIFT_W-1:0]    cfg_data,
    input  logic                            req_valid,
    input  logic                            req_stall,
    input  logic [rfta_pkg::ADDR_W-1:0]     virt_addr,
    input  logic                            rsp_valid,
    input  logic                            rsp_stall,
    input  logic [rfta_pkg::ADDR_W-1:0]     phys_addr,
    input  logic                            region_allocated,
    input  logic                            page_recorded,
    input  logic                            table_full,
    output int                              mismatches,
    output int                              pending
);

    logic [rfta_pkg::SHIFT_W-1:0] page_shift_q;
    logic [rfta_pkg::SHIFT_W-1:0] region_shift_q;

    bit                          region_used  [rfta_pkg::REGION_ENTRIES];
    logic [rfta_pkg::ADDR_W-1:0] region_key   [rfta_pkg::REGION_ENTRIES];
    logic [rfta_pkg::ADDR_W-1:0] region_frame [rfta_pkg::REGION_ENTRIES];
    bit                          page_used    [rfta_pkg::PAGE_ENTRIES];
    logic [rfta_pkg::ADDR_W-1:0] page_key     [rfta_pkg::PAGE_ENTRIES];
    logic [rfta_pkg::ADDR_W-1:0] frame_next;

    rfta_pkg::result_t expected_results[$];
    int                mismatch_count;

    // Translates one address and updates the tables as the block does.
    function automatic rfta_pkg::result_t translate(input logic [rfta_pkg::ADDR_W-1:0] va);
        rfta_pkg::result_t            res;
        logic [rfta_pkg::SHIFT_W-1:0] eff;
        logic [rfta_pkg::ADDR_W-1:0]  vpn;
        logic [rfta_pkg::ADDR_W-1:0]  region;
        logic [rfta_pkg::ADDR_W-1:0]  offset;
        logic [rfta_pkg::ADDR_W-1:0]  frame;
        int                           slot;
        bit                           fresh;

        res    = '0;
        fresh  = 1'b0;
        eff    = (region_shift_q < page_shift_q) ? page_shift_q : region_shift_q;
        vpn    = va >> page_shift_q;
        region = va >> eff;
        offset = va & ((64'd1 << eff) - 64'd1);

        slot = -1;
        for (int i = 0; i < rfta_pkg::REGION_ENTRIES; i++)
            if (slot < 0 && region_used[i] && region_key[i] == region)
                slot = i;
        if (slot < 0) begin
            for (int i = 0; i < rfta_pkg::REGION_ENTRIES; i++)
                if (slot < 0 && !region_used[i])
                    slot = i;
            // With no free region cell nothing at all is stored.
            if (slot < 0) begin
                res.full = 1'b1;
                return res;
            end
            region_used[slot]  = 1'b1;
            region_key[slot]   = region;
            region_frame[slot] = frame_next;
            frame_next         = frame_next + 64'd1;
            fresh              = 1'b1;
        end
        frame     = region_frame[slot];
        res.pa    = (frame << eff) | offset;
        res.alloc = fresh;

        slot = -1;
        for (int i = 0; i < rfta_pkg::PAGE_ENTRIES; i++)
            if (slot < 0 && page_used[i] && page_key[i] == vpn)
                slot = i;
        if (slot < 0) begin
            for (int i = 0; i < rfta_pkg::PAGE_ENTRIES; i++)
                if (slot < 0 && !page_used[i])
                    slot = i;
            if (slot < 0) begin
                res.full = 1'b1;
            end
            else begin
                page_used[slot] = 1'b1;
                page_key[slot]  = vpn;
                res.recorded    = 1'b1;
            end
        end
        return res;
    endfunction

    task automatic check_result();
        rfta_pkg::result_t exp;

        if (expected_results.size() == 0) begin
            $display("%0t: result with none expected: phys_addr %h", $time,
                     phys_addr);
            mismatch_count++;
            return;
        end
        exp = expected_results.pop_front();
        if (phys_addr !== exp.pa) begin
            $display("%0t: phys_addr expected %h actual %h", $time, exp.pa,
                     phys_addr);
            mismatch_count++;
        end
        if (region_allocated !== exp.alloc) begin
            $display("%0t: region_allocated expected %b actual %b", $time, exp.alloc,
                     region_allocated);
            mismatch_count++;
        end
        if (page_recorded !== exp.recorded) begin
            $display("%0t: page_recorded expected %b actual %b", $time, exp.recorded,
                     page_recorded);
            mismatch_count++;
        end
        if (table_full !== exp.full) begin
            $display("%0t: table_full expected %b actual %b", $time, exp.full, table_full);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            page_shift_q   <= rfta_pkg::PAGE_SHIFT_RESET;
            region_shift_q <= rfta_pkg::REGION_SHIFT_RESET;
            for (int i = 0; i < rfta_pkg::REGION_ENTRIES; i++)
                region_used[i] = 1'b0;
            for (int i = 0; i < rfta_pkg::PAGE_ENTRIES; i++)
                page_used[i] = 1'b0;
            frame_next = '0;
            expected_results.delete();
            mismatch_count = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    rfta_pkg::CFG_PAGE_SHIFT:   page_shift_q   <= cfg_data;
                    rfta_pkg::CFG_REGION_SHIFT: region_shift_q <= cfg_data;
                    default: ;
                endcase
            end
            // The result is checked before the new request is predicted, so a
            // spurious result can never pair with a request of the same edge.
            if (rsp_valid && !rsp_stall)
                check_result();
            if (req_valid && !req_stall)
                expected_results.push_back(translate(virt_addr));
            pending    <= expected_results.size();
            mismatches <= mismatch_count;
        end
    end

endmodule

// File: verif/region_first_touch_allocator_test.sv
// Top of the allocator testbench. It drives reset, the register port and the
// request channel, stalls the response channel, and gives the verdict. All
// prediction and comparison lives in the translation checker beside the block.
module region_first_touch_allocator_test;

    import rfta_pkg::*;

    // Every request walks both chains of table cells, one cell per cycle while req_stall is low.
    localparam int LATENCY     = REGION_ENTRIES + PAGE_ENTRIES + 3;
    localparam int DRAIN_LIMIT = 100000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PAGE_SHIFT;
    logic [SHIFT_W-1:0]   cfg_data  = '0;
    logic                 req_valid = 1'b0;
    logic [ADDR_W-1:0]    virt_addr = '0;
    logic                 rsp_stall = 1'b0;

    logic              req_stall;
    logic              rsp_valid;
    logic [ADDR_W-1:0] phys_addr;
    logic              region_allocated;
    logic              page_recorded;
    logic              table_full;

    int mismatches;
    int pending;

    // Idle rates in percent; they move through three modes as transfers go by.
    int send_gap_pct   = 10;
    int recv_stall_pct = 86;
    int sent_count     = 0;

    // Every address sent so far, and the few addresses a random phase is
    // built around.
    logic [ADDR_W-1:0] sent_addrs[$];
    logic [ADDR_W-1:0] anchors[$];

    region_first_touch_allocator DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .virt_addr        (virt_addr),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .phys_addr        (phys_addr),
        .region_allocated (region_allocated),
        .page_recorded    (page_recorded),
        .table_full       (table_full)
    );

    rfta_translation_check xlate_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .virt_addr        (virt_addr),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .phys_addr        (phys_addr),
        .region_allocated (region_allocated),
        .page_recorded    (page_recorded),
        .table_full       (table_full),
        .mismatches       (mismatches),
        .pending          (pending)
    );

    always #5 clk = ~clk;

    // The receiver decides every cycle whether to hold off the next result.
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [ADDR_W-1:0] low_mask(input logic [SHIFT_W-1:0] bits);
        return (64'd1 << bits) - 64'd1;
    endfunction

    // Sends one address and returns at the edge where its transfer happens.
    // Valid stays high afterwards, so back-to-back items need no extra edge.
    task automatic issue(input logic [ADDR_W-1:0] va);
        if (sent_count < 175) begin
            send_gap_pct   = 10;
            recv_stall_pct = 86;
        end
        else if (sent_count < 350) begin
            send_gap_pct   = 86;
            recv_stall_pct = 10;
        end
        else begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
        end
        while ($urandom_range(99) < send_gap_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        virt_addr <= va;
        do
            @(posedge clk);
        while (req_stall);
        sent_addrs.push_back(va);
        sent_count++;
    endtask

    // Drops valid and waits until every predicted result has come back. The
    // count from the checker is registered, so the first look waits for an edge.
    task automatic wait_drained();
        int guard;

        guard = 0;
        req_valid <= 1'b0;
        do begin
            @(posedge clk);
            guard++;
        end while (pending != 0 && guard < DRAIN_LIMIT);
    endtask

    // Writes both shift registers back to back while the block is idle.
    task automatic set_shifts(input logic [SHIFT_W-1:0] ps, input logic [SHIFT_W-1:0] rs);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PAGE_SHIFT;
        cfg_data  <= ps;
        @(posedge clk);
        cfg_index <= CFG_REGION_SHIFT;
        cfg_data  <= rs;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // One random phase at fixed shifts. Items are a mix of three kinds:
    // repeats in the page of an anchor or an earlier address (hits in both
    // tables once stored), new pages in the region of an anchor (page table
    // growth only), and fully random addresses (new regions, all bits toggling).
    task automatic random_phase(input logic [SHIFT_W-1:0] ps, input logic [SHIFT_W-1:0] rs,
                                input int count, input int anchor_count,
                                input int repeat_pct, input int spread_pct);
        logic [ADDR_W-1:0]  va;
        logic [SHIFT_W-1:0] eff;
        int                 pick;

        set_shifts(ps, rs);
        eff = (rs < ps) ? ps : rs;
        anchors.delete();
        repeat (anchor_count) anchors.push_back(rand64());
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < repeat_pct) begin
                if ($urandom_range(1) == 0)
                    va = anchors[$urandom_range(anchors.size() - 1)];
                else
                    va = sent_addrs[$urandom_range(sent_addrs.size() - 1)];
                va = va ^ (rand64() & low_mask(ps));
            end
            else if (pick < repeat_pct + spread_pct) begin
                va = anchors[$urandom_range(anchors.size() - 1)];
                va = (va & ~low_mask(eff)) | (rand64() & low_mask(eff));
            end
            else begin
                case ($urandom_range(15))
                    0:       va = '0;
                    1:       va = '1;
                    default: va = rand64();
                endcase
            end
            issue(va);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset shifts: address extremes, alternating
        // bit patterns, and repeats that hit both tables.
        issue(64'h0000_0000_0000_0000);
        issue(64'h0000_0000_0000_0FFF);
        issue(64'hFFFF_FFFF_FFFF_FFFF);
        issue(64'h8000_0000_0000_0000);
        issue(64'h5555_5555_5555_5555);
        issue(64'hAAAA_AAAA_AAAA_AAAA);
        issue(64'h0000_0000_0030_0000);
        issue(64'hFFFF_FFFF_FFFF_F000);

        // Byte-sized pages and regions: region numbers now collide with the
        // ones stored under the old shifts.
        set_shifts(6'd0, 6'd0);
        issue(64'h0000_0000_0000_0000);
        issue(64'h0000_0000_0000_0001);
        issue(64'hFFFF_FFFF_FFFF_FFFF);

        // Largest shifts: only region numbers zero and one exist.
        set_shifts(6'd63, 6'd63);
        issue(64'hFFFF_FFFF_FFFF_FFFF);
        issue(64'h7FFF_FFFF_FFFF_FFFF);

        // Region shift below page shift, so the page shift rules the region.
        set_shifts(6'd63, 6'd0);
        issue(64'h1234_5678_9ABC_DEF0);

        // One huge region holding byte pages.
        set_shifts(6'd0, 6'd63);
        issue(64'h1234_5678_9ABC_DEF0);

        // A page known from the first shifts lands in a newly allocated
        // region, then a new page follows inside that same region.
        set_shifts(6'd12, 6'd20);
        issue(64'h0000_0000_0030_0000);
        issue(64'h0000_0000_0030_1000);

        // Random phases. The page table fills during the byte-page phase while
        // region cells remain; the next phase then allocates regions with the
        // page table full and finally runs the region table out as well.
        random_phase(6'd12, 6'd12, 80, 6, 88, 0);
        random_phase(6'd0, 6'd16, 240, 4, 2, 95);
        random_phase(6'd8, 6'd8, 60, 4, 60, 0);
        random_phase(6'd63, 6'd0, 40, 2, 50, 30);
        random_phase(6'd0, 6'd63, 40, 2, 40, 40);
        random_phase(6'd12, 6'd12, 40, 4, 70, 0);

        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
rtl/rfta_pkg.sv
rtl/rfta_region_cell.sv
rtl/rfta_page_cell.sv
rtl/rfta_out_queue.sv
rtl/region_first_touch_allocator.sv
verif/rfta_translation_check.sv
verif/region_first_touch_allocator_test.sv
